// File: design/rgpc_pkg.sv
`default_nettype none

package rgpc_pkg;

    // Field widths of the input and result items.
    localparam int RADIUS_W = 16;
    localparam int HEIGHT_W = 16;
    localparam int TAG_W    = 16;

    // Configuration register widths.
    localparam int SENSOR_H_W = 12;
    localparam int TAN_W      = 16;
    localparam int MIN_H_W    = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Stream payload widths.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // Stored previous height covers both a point height and the floor height.
    localparam int LAST_H_W = HEIGHT_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_LOCAL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_GENERAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_RING     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOCAL_H   = 3'd4;

    // Register values after reset.
    localparam logic [SENSOR_H_W-1:0] RST_SENSOR_HEIGHT = 12'd370;
    localparam logic [TAN_W-1:0]      RST_TAN_LOCAL     = 16'd5734;
    localparam logic [TAN_W-1:0]      RST_TAN_GENERAL   = 16'd3435;
    localparam logic [RADIUS_W-1:0]   RST_NEAR_RING     = 16'd100;
    localparam logic [MIN_H_W-1:0]    RST_MIN_LOCAL_H   = 12'd50;

    typedef struct packed {
        logic [SENSOR_H_W-1:0] sensor_height_mm;
        logic [TAN_W-1:0]      tan_local_slope;
        logic [TAN_W-1:0]      tan_general_slope;
        logic [RADIUS_W-1:0]   near_ring_mm;
        logic [MIN_H_W-1:0]    min_local_height_mm;
    } cfg_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius_mm;
        logic [HEIGHT_W-1:0] height_mm;
        logic                ray_start;
        logic [TAG_W-1:0]    point_tag;
    } item_t;

    // Previous point of the current ray.
    typedef struct packed {
        logic [RADIUS_W-1:0] last_radius;
        logic [LAST_H_W-1:0] last_height;
        logic                last_was_ground;
    } ray_state_t;

endpackage

`default_nettype wire

// File: design/rgpc_cfg_regs.sv
`default_nettype none

module rgpc_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rgpc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [rgpc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output rgpc_pkg::cfg_t                      cfg
);
    import rgpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; each value is cut to its register's width.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_SENSOR_HEIGHT: cfg_next.sensor_height_mm    = cfg_wr_data[SENSOR_H_W-1:0];
                CFG_TAN_LOCAL:     cfg_next.tan_local_slope     = cfg_wr_data[TAN_W-1:0];
                CFG_TAN_GENERAL:   cfg_next.tan_general_slope   = cfg_wr_data[TAN_W-1:0];
                CFG_NEAR_RING:     cfg_next.near_ring_mm        = cfg_wr_data[RADIUS_W-1:0];
                CFG_MIN_LOCAL_H:   cfg_next.min_local_height_mm = cfg_wr_data[MIN_H_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensor_height_mm    <= RST_SENSOR_HEIGHT;
            cfg_reg.tan_local_slope     <= RST_TAN_LOCAL;
            cfg_reg.tan_general_slope   <= RST_TAN_GENERAL;
            cfg_reg.near_ring_mm        <= RST_NEAR_RING;
            cfg_reg.min_local_height_mm <= RST_MIN_LOCAL_H;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/rgpc_classify.sv
`default_nettype none

module rgpc_classify (
    input  rgpc_pkg::item_t      item,
    input  rgpc_pkg::cfg_t       cfg,
    input  rgpc_pkg::ray_state_t state_in,
    output rgpc_pkg::ray_state_t state_out,
    output logic                 is_ground
);
    import rgpc_pkg::*;

    ray_state_t          prev;
    logic signed [16:0]  diff_r;
    logic signed [33:0]  local_prod;
    logic signed [33:0]  min_thr;
    logic signed [33:0]  local_thr;
    logic                far_point;
    logic signed [17:0]  dh;
    logic [16:0]         abs_dh;
    logic signed [17:0]  dg;
    logic [16:0]         abs_dg;
    logic [31:0]         general_thr;
    logic                level;
    logic                in_general;
    logic                ground;

    // A new ray starts from the floor directly under the sensor.
    always_comb begin
        prev = state_in;
        if (item.ray_start) begin
            prev.last_radius     = '0;
            prev.last_height     = 17'(-$signed({5'b0, cfg.sensor_height_mm}));
            prev.last_was_ground = 1'b0;
        end
    end

    // Local band half-width: tangent times the radius step, with a floor far out.
    assign diff_r     = $signed({1'b0, item.radius_mm}) - $signed({1'b0, prev.last_radius});
    assign local_prod = $signed({1'b0, cfg.tan_local_slope}) * diff_r;
    assign min_thr    = $signed({6'b0, cfg.min_local_height_mm, 16'b0});
    assign far_point  = item.radius_mm > cfg.near_ring_mm;
    assign local_thr  = (far_point && (local_prod < min_thr)) ? min_thr : local_prod;

    // General band half-width grows with distance from the sensor.
    assign general_thr = cfg.tan_general_slope * item.radius_mm;

    // Height offsets against the previous point and against the floor.
    assign dh     = $signed({item.height_mm[HEIGHT_W-1], item.height_mm[HEIGHT_W-1],
                             item.height_mm})
                  - $signed({prev.last_height[LAST_H_W-1], prev.last_height});
    assign abs_dh = dh[17] ? 17'(-dh) : dh[16:0];
    assign dg     = $signed({item.height_mm[HEIGHT_W-1], item.height_mm[HEIGHT_W-1],
                             item.height_mm})
                  + $signed({6'b0, cfg.sensor_height_mm});
    assign abs_dg = dg[17] ? 17'(-dg) : dg[16:0];

    // Both comparisons are made with the offset scaled to the Q.16 band.
    assign level      = $signed({1'b0, abs_dh, 16'b0}) <= local_thr;
    assign in_general = {abs_dg, 16'b0} <= {1'b0, general_thr};
    assign ground     = level && (prev.last_was_ground || in_general);

    assign is_ground                 = ground;
    assign state_out.last_radius     = item.radius_mm;
    assign state_out.last_height     = {item.height_mm[HEIGHT_W-1], item.height_mm};
    assign state_out.last_was_ground = ground;

endmodule

`default_nettype wire

// File: design/ray_ground_point_classifier_top.sv
`default_nettype none

// Classifies lidar points as ground or not, one item per clock cycle sustained
// while m_tready stays high. Points of each ray must arrive sorted by radius,
// with s_tuser set on the first point of a ray. An accepted item is held in the
// input item register and then the result register, which carries its tag
// in m_tdata and the ground flag in m_tuser. The rate is set by the one-point
// feedback loop: the previous point's radius, height and ground flag feed a
// subtract, one 16 x 17 bit multiply and a compare combinationally, back into
// the state register. Configuration writes take effect on the next item and
// belong in idle time, when no item is in flight.
module ray_ground_point_classifier_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write port.
    input  wire logic                            cfg_wr_en,
    input  wire logic [rgpc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [rgpc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // Input stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: radius_mm[15:0], height_mm[31:16], point_tag[47:32].
    input  wire logic [rgpc_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: ray_start.
    input  wire logic                            s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Fields from bit 0: tag_out[15:0].
    output logic [rgpc_pkg::M_TDATA_W-1:0]       m_tdata,
    // Fields from bit 0: is_ground.
    output logic                                 m_tuser
);
    import rgpc_pkg::*;

    cfg_t       cfg;
    item_t      in_item_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    ray_state_t state_reg;
    ray_state_t state_next;
    logic       ground;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_ground_reg;
    logic [TAG_W-1:0] out_tag_reg;
    logic       s_accept;
    logic       advance;

    rgpc_cfg_regs u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    rgpc_classify u_classify (
        .item      (in_item_reg),
        .cfg       (cfg),
        .state_in  (state_reg),
        .state_out (state_next),
        .is_ground (ground)
    );

    // The held item moves on whenever the result register is free or drains.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and the previous point of the ray.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.radius_mm <= s_tdata[15:0];
            in_item_reg.height_mm <= s_tdata[31:16];
            in_item_reg.point_tag <= s_tdata[47:32];
            in_item_reg.ray_start <= s_tuser;
        end
        if (advance) begin
            out_ground_reg <= ground;
            out_tag_reg    <= in_item_reg.point_tag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tag_reg;
    assign m_tuser  = out_ground_reg;

endmodule

`default_nettype wire

// File: design/rgpc_checker.sv
`default_nettype none

module rgpc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rgpc_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                            m_tuser
);
    import rgpc_pkg::*;

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result keeps its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input back-pressure only comes from a full, stalled result register.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while result side free");

    // A fresh result follows an item accepted into the input item register.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without an accepted item");

endmodule

bind ray_ground_point_classifier_top rgpc_checker u_rgpc_checker (.*);

`default_nettype wire
